// ===== rtl/core/cfwd_pkg.sv =====
// Package for the checked frame word decoder.
// Holds sizes, status codes and the controller/datapath command and status structs.
`timescale 1ns / 1ps

package cfwd_pkg;

   localparam int POINTS_COUNT   = 8;
   localparam int POSITION_WORDS = 3;
   localparam int STORE_DEPTH    = (POINTS_COUNT > POSITION_WORDS) ? POINTS_COUNT
                                                                   : POSITION_WORDS;
   localparam int IDX_W          = $clog2(STORE_DEPTH);
   localparam int CNT_W          = $clog2(4 * STORE_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SUM_ERR  = 2'd1,
      STATUS_TYPE_ERR = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OUT_TYPE_ERR = 2'd0,
      OUT_SUM_ERR  = 2'd1,
      OUT_WORD     = 2'd2
   } out_sel_type;

   typedef struct packed {
      logic        load_frame;
      logic        load_byte;
      logic        rd_start;
      logic        rd_advance;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic type_ok;
      logic payload_done;
      logic sum_match;
      logic drain_last;
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/core/cfwd_datapath.sv =====
// Datapath of the checked frame word decoder: byte counter, checksum, word
// assembly, word store and output register. Depends on cfwd_pkg.
`timescale 1ns / 1ps

module cfwd_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       req_data_byte,
   input  cfwd_pkg::cmd_type cmd,
   output cfwd_pkg::sts_type sts,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic             rsp_msg_type,
   output logic [4:0]       rsp_word_index,
   output logic [31:0]      rsp_word_value,
   output logic             rsp_last
);
   import cfwd_pkg::*;

   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]       xor_sum_ff, xor_sum_in;
   logic [23:0]      partial_word_ff, partial_word_in;
   logic             frame_kind_ff, frame_kind_in;
   logic [IDX_W-1:0] drain_idx_ff, drain_idx_in;
   logic [31:0]      store_mem_ff [STORE_DEPTH];
   logic [31:0]      rd_data_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic             msg_type_ff, msg_type_in;
   logic [4:0]       word_index_ff, word_index_in;
   logic [31:0]      word_value_ff, word_value_in;
   logic             last_ff, last_in;

   logic [1:0]       lane;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] words_m1;
   logic [CNT_W-1:0] payload_bytes;

   assign lane          = byte_count_ff[1:0];
   assign wr_idx        = byte_count_ff[IDX_W+1:2];
   assign words_m1      = frame_kind_ff ? IDX_W'(POINTS_COUNT - 1) : IDX_W'(POSITION_WORDS - 1);
   assign payload_bytes = frame_kind_ff ? CNT_W'(4 * POINTS_COUNT) : CNT_W'(4 * POSITION_WORDS);

   assign sts.type_ok      = (req_data_byte[7:1] == 7'd0);
   assign sts.payload_done = (byte_count_ff == payload_bytes);
   assign sts.sum_match    = (req_data_byte == xor_sum_ff);
   assign sts.drain_last   = (drain_idx_ff == words_m1);
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;

   always_comb begin
      byte_count_in   = byte_count_ff;
      xor_sum_in      = xor_sum_ff;
      partial_word_in = partial_word_ff;
      frame_kind_in   = frame_kind_ff;
      drain_idx_in    = drain_idx_ff;
      if (cmd.load_frame) begin
         byte_count_in = '0;
         xor_sum_in    = req_data_byte;
         frame_kind_in = req_data_byte[0];
      end else if (cmd.load_byte) begin
         byte_count_in = byte_count_ff + CNT_W'(1);
         xor_sum_in    = xor_sum_ff ^ req_data_byte;
         case (lane)
            2'd0:    partial_word_in[7:0]   = req_data_byte;
            2'd1:    partial_word_in[15:8]  = req_data_byte;
            2'd2:    partial_word_in[23:16] = req_data_byte;
            default: partial_word_in        = partial_word_ff;
         endcase
      end
      if (cmd.rd_start) begin
         drain_idx_in = '0;
      end else if (cmd.rd_advance) begin
         drain_idx_in = drain_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         xor_sum_ff    <= '0;
         frame_kind_ff <= 1'b0;
         drain_idx_ff  <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         xor_sum_ff    <= xor_sum_in;
         frame_kind_ff <= frame_kind_in;
         drain_idx_ff  <= drain_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      partial_word_ff <= partial_word_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte && (lane == 2'd3)) begin
         store_mem_ff[wr_idx] <= {req_data_byte, partial_word_ff};
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem_ff[drain_idx_ff];
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      status_in     = status_ff;
      msg_type_in   = msg_type_ff;
      word_index_in = word_index_ff;
      word_value_in = word_value_ff;
      last_in       = last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         unique case (cmd.out_sel)
            OUT_TYPE_ERR: begin
               status_in     = STATUS_TYPE_ERR;
               msg_type_in   = 1'b0;
               word_index_in = 5'd0;
               word_value_in = 32'd0;
               last_in       = 1'b1;
            end
            OUT_SUM_ERR: begin
               status_in     = STATUS_SUM_ERR;
               msg_type_in   = frame_kind_ff;
               word_index_in = 5'd0;
               word_value_in = 32'd0;
               last_in       = 1'b1;
            end
            OUT_WORD: begin
               status_in     = STATUS_OK;
               msg_type_in   = frame_kind_ff;
               word_index_in = 5'(drain_idx_ff);
               word_value_in = rd_data_ff;
               last_in       = sts.drain_last;
            end
            default: begin
               status_in     = STATUS_TYPE_ERR;
               msg_type_in   = 1'b0;
               word_index_in = 5'd0;
               word_value_in = 32'd0;
               last_in       = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      msg_type_ff   <= msg_type_in;
      word_index_ff <= word_index_in;
      word_value_ff <= word_value_in;
      last_ff       <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_msg_type   = msg_type_ff;
   assign rsp_word_index = word_index_ff;
   assign rsp_word_value = word_value_ff;
   assign rsp_last       = last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("output register loaded while an item is pending");

   a_byte_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_byte |-> (byte_count_ff < payload_bytes))
      else $error("payload byte taken past the end of the frame");

   a_drain_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && (cmd.out_sel == OUT_WORD)) |-> (drain_idx_ff <= words_m1))
      else $error("drain index past the last word");

endmodule

// ===== rtl/core/cfwd_ctrl.sv =====
// Controller of the checked frame word decoder: frame collection and word drain.
// Drives the datapath through cmd_type, reads sts_type. Depends on cfwd_pkg.
`timescale 1ns / 1ps

module cfwd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_frame_start,
   output logic              req_ready,
   input  cfwd_pkg::sts_type sts,
   output cfwd_pkg::cmd_type cmd
);
   import cfwd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FRAME = 4'b0010,
      ST_READ  = 4'b0100,
      ST_SEND  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = ((state_ff == ST_IDLE) || (state_ff == ST_FRAME)) && sts.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.out_sel    = OUT_WORD;
      unique case (state_ff) inside
         ST_IDLE, ST_FRAME: begin
            if (accept && req_frame_start) begin
               if (sts.type_ok) begin
                  cmd.load_frame = 1'b1;
                  state_in       = ST_FRAME;
               end else begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = OUT_TYPE_ERR;
                  state_in     = ST_IDLE;
               end
            end else if (accept && (state_ff == ST_FRAME)) begin
               if (!sts.payload_done) begin
                  cmd.load_byte = 1'b1;
               end else if (sts.sum_match) begin
                  cmd.rd_start = 1'b1;
                  state_in     = ST_READ;
               end else begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = OUT_SUM_ERR;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_WORD;
               if (sts.drain_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_advance = 1'b1;
                  state_in       = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_take_in_drain: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) || (state_ff == ST_SEND)) |-> !req_ready)
      else $error("input taken during drain");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SEND) && sts.out_free && sts.drain_last) |=> (state_ff == ST_IDLE))
      else $error("drain did not end after the last word");

   a_read_then_send: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_SEND))
      else $error("store read not followed by send");

endmodule

// ===== rtl/core/checked_frame_word_decoder.sv =====
// Top level of the checked frame word decoder.
// Joins cfwd_ctrl and cfwd_datapath. Depends on cfwd_pkg.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | req_data_byte, req_frame_start
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_status, rsp_msg_type,
//           |           |                        | rsp_word_index, rsp_word_value, rsp_last
//
// One byte is taken per cycle while a frame is collected; a result held in the
// output register under a low rsp_ready holds off the next byte.
// After a good checksum, each word drains through a store read, then a load
// of the output register; no byte is taken during the drain.
// Reset is synchronous and active high; it returns the block to idle.
// A stalled rsp_ready holds the output register and stops input and drain.
`timescale 1ns / 1ps

module checked_frame_word_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_msg_type,
   output logic [4:0]  rsp_word_index,
   output logic [31:0] rsp_word_value,
   output logic        rsp_last
);
   import cfwd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cfwd_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_frame_start (req_frame_start),
      .req_ready       (req_ready),
      .sts             (sts),
      .cmd             (cmd)
   );

   cfwd_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_data_byte  (req_data_byte),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_msg_type   (rsp_msg_type),
      .rsp_word_index (rsp_word_index),
      .rsp_word_value (rsp_word_value),
      .rsp_last       (rsp_last)
   );

endmodule
